/* rtl/isc_pkg.sv */
// Shared types, codes and constants for the irrigation schedule controller.
// No dependencies; imported by every module of the block except isc_ram.
package isc_pkg;

   localparam int SLOTS_DEF  = 32;
   localparam int VALVES_DEF = 4;

   localparam logic [15:0] WARN_RESET  = 16'd30;
   localparam logic [15:0] LIMIT_RESET = 16'd60;
   localparam logic [15:0] MINUTES_MAX = 16'hFFFF;

   // request actions
   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_CREATE = 3'd1;
   localparam logic [2:0] ACT_MODIFY = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_MAN_ON = 3'd4;
   localparam logic [2:0] ACT_MAN_OFF = 3'd5;

   // event codes
   localparam logic [3:0] EV_DONE       = 4'd0;
   localparam logic [3:0] EV_AUTO_START = 4'd1;
   localparam logic [3:0] EV_AUTO_STOP  = 4'd2;
   localparam logic [3:0] EV_MAN_START  = 4'd3;
   localparam logic [3:0] EV_MAN_STOP   = 4'd4;
   localparam logic [3:0] EV_FORCED     = 4'd5;
   localparam logic [3:0] EV_WARN       = 4'd6;
   localparam logic [3:0] EV_FULL       = 4'd7;
   localparam logic [3:0] EV_NOT_FOUND  = 4'd8;

   // register indexes
   localparam logic [0:0] CSR_WARN  = 1'b0;
   localparam logic [0:0] CSR_LIMIT = 1'b1;

   // session entry: key, enable, valve, start, duration, days
   typedef struct packed {
      logic [15:0] key;
      logic        enable;
      logic [1:0]  valve;
      logic [10:0] start;
      logic [10:0] dur;
      logic [6:0]  days;
   } session_type;

   localparam int SESSION_W = $bits(session_type);

   // controller to datapath commands
   typedef struct packed {
      logic load_req;     // capture request
      logic clr_idx;      // index <= 0
      logic inc_idx;      // index <= index + 1
      logic rd_slot;      // issue table read at index
      logic eval_slot;    // evaluate registered read data
      logic do_write;     // write the table (create/modify/delete)
      logic do_manual;    // manual on/off
      logic eval_valve;   // manual valve check at index
      logic emit_close;   // emit the closing result of the request
      logic pop_out;      // output register taken
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [2:0] action;
      logic       slot_end;   // index reached session count
      logic       valve_end;  // index reached last valve
      logic       match;      // read key matches request key
      logic       out_full;   // output register holds a result
      logic       full;       // table full
   } sts_type;

endpackage

/* rtl/isc_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module isc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/isc_datapath.sv */
// Datapath: request register, session RAM, running flags, manual counters,
// valve drive and result register. Depends on isc_pkg and isc_ram.
module isc_datapath #(
   parameter int SESSION_SLOTS = isc_pkg::SLOTS_DEF,
   parameter int VALVE_COUNT   = isc_pkg::VALVES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  isc_pkg::ctl_type   ctl,
   output isc_pkg::sts_type   sts,
   input  logic [2:0]         req_action,
   input  logic [10:0]        req_minute_of_day,
   input  logic [2:0]         req_day_of_week,
   input  logic [15:0]        req_session_key,
   input  logic               req_enable_bit,
   input  logic [1:0]         req_valve,
   input  logic [10:0]        req_start_minute,
   input  logic [10:0]        req_duration,
   input  logic [6:0]         req_day_mask,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_valid,
   output logic [3:0]         rsp_event_res,
   output logic [1:0]         rsp_event_valve,
   output logic [5:0]         rsp_event_slot,
   output logic [3:0]         rsp_valve_drive,
   output logic               rsp_last_result
);
   import isc_pkg::*;

   localparam int AW  = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int CW  = $clog2(SESSION_SLOTS + 1);
   localparam int IW  = (CW > 2) ? CW : 2;

   // request capture
   logic [2:0]  action_ff;
   logic [10:0] now_ff;
   logic [2:0]  day_ff;
   session_type req_ff;
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         action_ff    <= req_action;
         now_ff       <= req_minute_of_day;
         day_ff       <= req_day_of_week;
         req_ff.key   <= req_session_key;
         req_ff.enable <= req_enable_bit;
         req_ff.valve <= req_valve;
         req_ff.start <= req_start_minute;
         req_ff.dur   <= req_duration;
         req_ff.days  <= req_day_mask;
      end
   end

   // configuration registers
   logic [15:0] warn_ff, limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_ff  <= WARN_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_WARN) warn_ff <= csr_write_data;
         else limit_ff <= csr_write_data;
      end
   end

   // walk index and its copy for the registered read
   logic [IW-1:0] idx_ff, idx_in, rdx_ff;
   always_comb begin
      idx_in = idx_ff;
      if (ctl.clr_idx) idx_in = '0;
      else if (ctl.inc_idx) idx_in = idx_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rdx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (ctl.rd_slot) rdx_ff <= idx_ff;
      end
   end

   // session table
   logic [CW-1:0] count_ff;
   session_type   rd_entry, wr_entry;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SESSION_W-1:0] rd_raw;
   assign rd_entry = session_type'(rd_raw);

   // read the slot held in rdx so the data lines up with its slot number
   isc_ram #(.WIDTH(SESSION_W), .DEPTH(SESSION_SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (SESSION_W'(wr_entry)),
      .rd_addr (rdx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   // running flags, manual state, drive
   logic [SESSION_SLOTS-1:0] run_ff, run_in;
   logic [VALVE_COUNT-1:0]   man_ff, man_in, warned_ff, warned_in;
   logic [15:0]              mins_ff [VALVE_COUNT];
   logic [15:0]              mins_in [VALVE_COUNT];
   logic [3:0]               drive_ff, drive_in;
   logic [CW-1:0]            count_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [3:0] ev_ff, ev_in;
   logic [1:0] ev_valve_ff, ev_valve_in;
   logic [5:0] ev_slot_ff, ev_slot_in;
   logic       last_ff, last_in;

   logic          full;
   logic          match;
   logic [11:0]   end_min;
   logic          day_hit;
   logic          vok;
   logic [1:0]    vi;
   logic [15:0]   mnext;
   logic          out_set;

   assign full    = (count_ff == CW'(SESSION_SLOTS));
   assign match   = (rd_entry.key == req_ff.key);
   assign end_min = {1'b0, rd_entry.start} + {1'b0, rd_entry.dur};
   assign day_hit = (day_ff != 3'd7) && rd_entry.days[day_ff];
   assign vok     = (32'(rd_entry.valve) < VALVE_COUNT);
   assign vi      = idx_ff[1:0];
   assign mnext   = (mins_ff[vi] == MINUTES_MAX) ? MINUTES_MAX : mins_ff[vi] + 16'd1;

   always_comb begin
      run_in      = run_ff;
      man_in      = man_ff;
      warned_in   = warned_ff;
      mins_in     = mins_ff;
      drive_in    = drive_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_entry    = req_ff;
      out_set     = 1'b0;
      ev_in       = ev_ff;
      ev_valve_in = ev_valve_ff;
      ev_slot_in  = ev_slot_ff;
      last_in     = 1'b0;

      // evaluate one session slot
      if (ctl.eval_slot && (rd_entry.key != '0)) begin
         if (!run_ff[rdx_ff[AW-1:0]] && vok
             && !man_ff[rd_entry.valve] && day_hit
             && ({1'b0, rd_entry.start} < {1'b0, now_ff}) && (end_min > {1'b0, now_ff})
             && rd_entry.enable) begin
            drive_in[rd_entry.valve] = 1'b1;
            run_in[rdx_ff[AW-1:0]]   = 1'b1;
            out_set     = 1'b1;
            ev_in       = EV_AUTO_START;
            ev_valve_in = rd_entry.valve;
            ev_slot_in  = 6'(rdx_ff);
         end else if ((end_min < {1'b0, now_ff}) && run_ff[rdx_ff[AW-1:0]]) begin
            if (vok) drive_in[rd_entry.valve] = 1'b0;
            run_in[rdx_ff[AW-1:0]] = 1'b0;
            out_set     = 1'b1;
            ev_in       = EV_AUTO_STOP;
            ev_valve_in = rd_entry.valve;
            ev_slot_in  = 6'(rdx_ff);
         end
      end

      // age one manual valve
      if (ctl.eval_valve && man_ff[vi]) begin
         if (mnext > limit_ff) begin
            man_in[vi]  = 1'b0;
            mins_in[vi] = '0;
            drive_in[vi] = 1'b0;
            out_set     = 1'b1;
            ev_in       = EV_FORCED;
            ev_valve_in = vi;
            ev_slot_in  = '0;
         end else begin
            mins_in[vi] = mnext;
            if ((mnext > warn_ff) && !warned_ff[vi]) begin
               warned_in[vi] = 1'b1;
               out_set     = 1'b1;
               ev_in       = EV_WARN;
               ev_valve_in = vi;
               ev_slot_in  = '0;
            end
         end
      end

      // table writes and closing results
      if (ctl.do_write) begin
         ev_valve_in = req_ff.valve;
         ev_slot_in  = '0;
         case (action_ff)
            ACT_CREATE: begin
               if (full) begin
                  ev_in = EV_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  run_in[count_ff[AW-1:0]] = 1'b0;
                  count_in = count_ff + 1'b1;
                  ev_in    = EV_DONE;
                  ev_slot_in = 6'(count_ff);
               end
            end
            ACT_MODIFY, ACT_DELETE: begin
               if (match && !sts.slot_end) begin
                  wr_en   = 1'b1;
                  wr_addr = rdx_ff[AW-1:0];
                  if (action_ff == ACT_DELETE) begin
                     wr_entry = rd_entry;
                     wr_entry.key = '0;
                  end
                  ev_in      = EV_DONE;
                  ev_slot_in = 6'(rdx_ff);
               end else begin
                  ev_in = EV_NOT_FOUND;
               end
            end
            default: begin
               ev_in = EV_DONE;
            end
         endcase
      end

      // manual on and off
      if (ctl.do_manual) begin
         ev_valve_in = req_ff.valve;
         ev_slot_in  = '0;
         if (32'(req_ff.valve) >= VALVE_COUNT) begin
            ev_in = EV_NOT_FOUND;
         end else if (action_ff == ACT_MAN_ON) begin
            man_in[req_ff.valve]    = 1'b1;
            mins_in[req_ff.valve]   = '0;
            warned_in[req_ff.valve] = 1'b0;
            drive_in[req_ff.valve] = 1'b1;
            ev_in = EV_MAN_START;
         end else begin
            man_in[req_ff.valve]  = 1'b0;
            mins_in[req_ff.valve] = '0;
            drive_in[req_ff.valve] = 1'b0;
            ev_in = EV_MAN_STOP;
         end
      end

      // closing result of a tick or an unknown action
      if (ctl.emit_close && !ctl.do_write && !ctl.do_manual) begin
         ev_in       = EV_DONE;
         ev_valve_in = '0;
         ev_slot_in  = '0;
      end
      if (ctl.emit_close) begin
         out_set = 1'b1;
         last_in = 1'b1;
      end

      out_valid_in = out_set | (out_valid_ff & ~ctl.pop_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         man_ff       <= '0;
         warned_ff    <= '0;
         drive_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int v = 0; v < VALVE_COUNT; v++) mins_ff[v] <= '0;
      end else begin
         run_ff       <= run_in;
         man_ff       <= man_in;
         warned_ff    <= warned_in;
         drive_ff     <= drive_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         mins_ff      <= mins_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      if (out_set) begin
         ev_ff       <= ev_in;
         ev_valve_ff <= ev_valve_in;
         ev_slot_ff  <= ev_slot_in;
         last_ff     <= last_in;
      end
   end

   assign sts.action    = action_ff;
   assign sts.slot_end  = (rdx_ff >= IW'(count_ff));
   assign sts.valve_end = (idx_ff == IW'(VALVE_COUNT - 1));
   assign sts.match     = match;
   assign sts.out_full  = out_valid_ff;
   assign sts.full      = full;

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_event_valve = ev_valve_ff;
   assign rsp_event_slot  = ev_slot_ff;
   assign rsp_valve_drive = drive_ff;
   assign rsp_last_result = last_ff;
endmodule

/* rtl/isc_ctrl.sv */
// Controller state machine: sequences the session walk, the valve walk and
// the key search. Depends on isc_pkg.
module isc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_ready,
   input  isc_pkg::sts_type sts,
   output isc_pkg::ctl_type ctl
);
   import isc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DISP   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SLOT   = 3'd3;
   localparam logic [2:0] ST_VALVE  = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_CLOSE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       pop;

   assign pop       = sts.out_full & rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.pop_out = pop;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               ctl.clr_idx  = 1'b1;
               state_in     = ST_DISP;
            end
         end
         // route by action; index is zero here
         ST_DISP: begin
            case (sts.action)
               ACT_TICK, ACT_MODIFY, ACT_DELETE: begin
                  ctl.rd_slot = 1'b1;
                  ctl.inc_idx = 1'b1;
                  state_in    = ST_READ;
               end
               default: state_in = ST_CLOSE;
            endcase
         end
         // read data lands next cycle
         ST_READ: begin
            state_in = (sts.action == ACT_TICK) ? ST_SLOT : ST_SEARCH;
         end
         // one slot per visit, wait while a result is pending
         ST_SLOT: begin
            if (sts.slot_end) begin
               ctl.clr_idx = 1'b1;
               ctl.rd_slot = 1'b1;
               state_in    = ST_VALVE;
            end else if (!sts.out_full || pop) begin
               ctl.eval_slot = 1'b1;
               ctl.rd_slot   = 1'b1;
               ctl.inc_idx   = 1'b1;
               state_in      = ST_READ;
            end
         end
         // one valve per cycle while no result is pending or the pending one is taken
         ST_VALVE: begin
            if (!sts.out_full || pop) begin
               ctl.eval_valve = 1'b1;
               ctl.rd_slot    = 1'b1;
               ctl.inc_idx    = 1'b1;
               if (sts.valve_end) state_in = ST_CLOSE;
            end
         end
         // compare keys until a match or the count
         ST_SEARCH: begin
            if (sts.match || sts.slot_end) begin
               state_in = ST_CLOSE;
            end else begin
               ctl.rd_slot = 1'b1;
               ctl.inc_idx = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_CLOSE: begin
            if (!sts.out_full || pop) begin
               ctl.emit_close = 1'b1;
               case (sts.action)
                  ACT_CREATE, ACT_MODIFY, ACT_DELETE: ctl.do_write = 1'b1;
                  ACT_MAN_ON, ACT_MAN_OFF: ctl.do_manual = 1'b1;
                  default: ;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* rtl/irrigation_schedule_controller_unit.sv */
// Irrigation schedule controller top level: controller plus datapath.
// Create, manual and unknown requests go straight to the closing state; modify and delete
// compare keys up to a match or the session count; a tick walks each slot in use, then
// each valve, one registered session RAM read per slot; a pending result stalls the walk.
// One request at a time: the next can be taken in the same cycle the last result appears.
// Sync reset clears count, flags, drive, result valid, presets limits; session RAM not cleared.
module irrigation_schedule_controller_unit #(
   parameter int SESSION_SLOTS = isc_pkg::SLOTS_DEF,
   parameter int VALVE_COUNT   = isc_pkg::VALVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [10:0] req_minute_of_day,
   input  logic [2:0]  req_day_of_week,
   input  logic [15:0] req_session_key,
   input  logic        req_enable_bit,
   input  logic [1:0]  req_valve,
   input  logic [10:0] req_start_minute,
   input  logic [10:0] req_duration,
   input  logic [6:0]  req_day_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_res,
   output logic [1:0]  rsp_event_valve,
   output logic [5:0]  rsp_event_slot,
   output logic [3:0]  rsp_valve_drive,
   output logic        rsp_last_result,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import isc_pkg::*;

   ctl_type ctl;
   sts_type sts;

   isc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   isc_datapath #(
      .SESSION_SLOTS (SESSION_SLOTS),
      .VALVE_COUNT   (VALVE_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_action        (req_action),
      .req_minute_of_day (req_minute_of_day),
      .req_day_of_week   (req_day_of_week),
      .req_session_key   (req_session_key),
      .req_enable_bit    (req_enable_bit),
      .req_valve         (req_valve),
      .req_start_minute  (req_start_minute),
      .req_duration      (req_duration),
      .req_day_mask      (req_day_mask),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_event_res     (rsp_event_res),
      .rsp_event_valve   (rsp_event_valve),
      .rsp_event_slot    (rsp_event_slot),
      .rsp_valve_drive   (rsp_valve_drive),
      .rsp_last_result   (rsp_last_result)
   );
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the irrigation schedule controller unit.
// Depends on rtl/isc_pkg.sv and rtl/irrigation_schedule_controller_unit.sv.
// A queued request driver, a response monitor and a built-in scheduler model.
`timescale 1ns / 100ps

module tb_top;
   import isc_pkg::*;

   typedef struct packed {
      logic [2:0]  action;
      logic [10:0] minute;
      logic [2:0]  day;
      logic [15:0] key;
      logic        en;
      logic [1:0]  valve;
      logic [10:0] start;
      logic [10:0] dur;
      logic [6:0]  days;
   } request_type;

   typedef struct packed {
      logic [3:0] ev;
      logic [1:0] valve;
      logic [5:0] slot;
      logic [3:0] drive;
      logic       last;
   } event_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [2:0]  req_action;
   logic [10:0] req_minute_of_day;
   logic [2:0]  req_day_of_week;
   logic [15:0] req_session_key;
   logic        req_enable_bit;
   logic [1:0]  req_valve;
   logic [10:0] req_start_minute;
   logic [10:0] req_duration;
   logic [6:0]  req_day_mask;
   logic        rsp_valid, rsp_ready;
   logic [3:0]  rsp_event_res;
   logic [1:0]  rsp_event_valve;
   logic [5:0]  rsp_event_slot;
   logic [3:0]  rsp_valve_drive;
   logic        rsp_last_result;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_write_data;

   irrigation_schedule_controller_unit u_dut (.*);

   // scheduler state mirror
   session_type sched_table [SLOTS_DEF];
   logic        sched_running [SLOTS_DEF];
   int          sched_count;
   logic        man_on [VALVES_DEF];
   logic [15:0] man_mins [VALVES_DEF];
   logic        man_warned [VALVES_DEF];
   logic [3:0]  drive_now;
   logic [15:0] warn_lim, stop_lim;

   request_type pending_requests[$];
   event_type   expected_events[$];
   logic [15:0] created_keys[$];
   request_type cur_req;
   int  errors;
   int  hold_left;
   bit  calm;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int find_session(logic [15:0] key);
      for (int i = 0; i < sched_count; i++)
         if (sched_table[i].key == key) return i;
      return -1;
   endfunction

   // compute the events one request causes and update the mirror
   function automatic void predict_request(request_type r);
      event_type evs[$];
      int k;
      logic [11:0] fin;
      case (r.action)
         ACT_TICK: begin
            for (int i = 0; i < sched_count; i++) begin
               if (sched_table[i].key == 0) continue;
               fin = sched_table[i].start + sched_table[i].dur;
               if (!sched_running[i] && !man_on[sched_table[i].valve] && r.day < 7 &&
                   sched_table[i].days[r.day] && sched_table[i].start < r.minute &&
                   fin > r.minute && sched_table[i].enable) begin
                  drive_now[sched_table[i].valve] = 1'b1;
                  sched_running[i] = 1'b1;
                  evs.push_back('{EV_AUTO_START, sched_table[i].valve, i[5:0], drive_now, 1'b0});
               end
               if (fin < r.minute && sched_running[i]) begin
                  drive_now[sched_table[i].valve] = 1'b0;
                  sched_running[i] = 1'b0;
                  evs.push_back('{EV_AUTO_STOP, sched_table[i].valve, i[5:0], drive_now, 1'b0});
               end
            end
            for (int v = 0; v < VALVES_DEF; v++) begin
               if (!man_on[v]) continue;
               if (man_mins[v] != MINUTES_MAX) man_mins[v]++;
               if (man_mins[v] > stop_lim) begin
                  man_on[v] = 1'b0;
                  man_mins[v] = 0;
                  drive_now[v] = 1'b0;
                  evs.push_back('{EV_FORCED, v[1:0], 6'd0, drive_now, 1'b0});
               end else if (man_mins[v] > warn_lim && !man_warned[v]) begin
                  man_warned[v] = 1'b1;
                  evs.push_back('{EV_WARN, v[1:0], 6'd0, drive_now, 1'b0});
               end
            end
            evs.push_back('{EV_DONE, 2'd0, 6'd0, drive_now, 1'b0});
         end
         ACT_CREATE: begin
            if (sched_count >= SLOTS_DEF)
               evs.push_back('{EV_FULL, r.valve, 6'd0, drive_now, 1'b0});
            else begin
               sched_table[sched_count] = '{r.key, r.en, r.valve, r.start, r.dur, r.days};
               sched_running[sched_count] = 1'b0;
               evs.push_back('{EV_DONE, r.valve, sched_count[5:0], drive_now, 1'b0});
               sched_count++;
            end
         end
         ACT_MODIFY, ACT_DELETE: begin
            k = find_session(r.key);
            if (k < 0)
               evs.push_back('{EV_NOT_FOUND, r.valve, 6'd0, drive_now, 1'b0});
            else begin
               if (r.action == ACT_MODIFY)
                  sched_table[k] = '{r.key, r.en, r.valve, r.start, r.dur, r.days};
               else
                  sched_table[k].key = 0;
               evs.push_back('{EV_DONE, r.valve, k[5:0], drive_now, 1'b0});
            end
         end
         ACT_MAN_ON: begin
            man_on[r.valve] = 1'b1;
            man_mins[r.valve] = 0;
            man_warned[r.valve] = 1'b0;
            drive_now[r.valve] = 1'b1;
            evs.push_back('{EV_MAN_START, r.valve, 6'd0, drive_now, 1'b0});
         end
         ACT_MAN_OFF: begin
            man_on[r.valve] = 1'b0;
            man_mins[r.valve] = 0;
            drive_now[r.valve] = 1'b0;
            evs.push_back('{EV_MAN_STOP, r.valve, 6'd0, drive_now, 1'b0});
         end
         default: evs.push_back('{EV_DONE, 2'd0, 6'd0, drive_now, 1'b0});
      endcase
      evs[evs.size()-1].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endfunction

   function automatic request_type make_req(logic [2:0] act, logic [10:0] minute,
                                            logic [2:0] day, logic [15:0] key, logic en,
                                            logic [1:0] valve, logic [10:0] start,
                                            logic [10:0] dur, logic [6:0] days);
      return '{act, minute, day, key, en, valve, start, dur, days};
   endfunction

   // mostly well-formed session traffic, some ticks at odd times and raw noise
   function automatic request_type random_req();
      request_type r;
      int pick;
      logic [15:0] key;
      r = make_req(ACT_TICK, 11'($urandom_range(1439)), 3'($urandom_range(6)),
                   16'($urandom_range(65535)), 1'($urandom_range(1)),
                   2'($urandom_range(3)), 11'($urandom_range(1439)),
                   11'($urandom_range(200)), 7'($urandom_range(127)));
      pick = $urandom_range(99);
      key = (created_keys.size() > 0 && $urandom_range(9) < 8) ?
            created_keys[$urandom_range(created_keys.size()-1)] : 16'($urandom_range(65535));
      if (pick < 12) begin
         r.action = ACT_CREATE;
         r.key = 16'($urandom_range(1, 65535));
         if ($urandom_range(9) == 0) r.dur = 11'($urandom_range(1439));
         created_keys.push_back(r.key);
      end else if (pick < 22) begin
         r.action = ACT_MODIFY;
         r.key = key;
      end else if (pick < 30) begin
         r.action = ACT_DELETE;
         r.key = key;
      end else if (pick < 42) r.action = ACT_MAN_ON;
      else if (pick < 52) r.action = ACT_MAN_OFF;
      else if (pick < 94) begin
         if ($urandom_range(19) == 0) r.day = 3'd7;
         if ($urandom_range(19) == 0) r.minute = 11'($urandom_range(2047));
      end else
         r = request_type'(58'({$urandom, $urandom}));
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_request(cur_req);
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
               cur_req = pending_requests.pop_front();
               req_action        <= cur_req.action;
               req_minute_of_day <= cur_req.minute;
               req_day_of_week   <= cur_req.day;
               req_session_key   <= cur_req.key;
               req_enable_bit    <= cur_req.en;
               req_valve         <= cur_req.valve;
               req_start_minute  <= cur_req.start;
               req_duration      <= cur_req.dur;
               req_day_mask      <= cur_req.days;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare against the oldest expected event
   always @(posedge clock) begin
      event_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_event_res, rsp_event_valve, rsp_event_slot, rsp_valve_drive,
                 rsp_last_result};
         if (expected_events.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_events.pop_front();
            if (got != want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
      rsp_ready <= !reset && hold_left == 0 && (calm || $urandom_range(99) >= 26);
   end

   // count down a receiver hold-off
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_events.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      if (idx == CSR_WARN) warn_lim = value;
      else stop_lim = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_phase(int n);
      repeat (n) pending_requests.push_back(random_req());
   endtask

   // abort a hung run
   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_action, req_minute_of_day, req_day_of_week, req_session_key, req_enable_bit,
       req_valve, req_start_minute, req_duration, req_day_mask} = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = 1'b0;
      csr_write_data = '0;
      errors = 0;
      hold_left = 0;
      calm = 1'b0;
      sched_count = 0;
      drive_now = '0;
      warn_lim = WARN_RESET;
      stop_lim = LIMIT_RESET;
      for (int v = 0; v < VALVES_DEF; v++) begin
         man_on[v] = 1'b0;
         man_mins[v] = '0;
         man_warned[v] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every action, deleted and zero keys
      pending_requests.push_back(make_req(ACT_CREATE, 0, 0, 16'hFFFF, 1, 3, 0, 1439, 7'h7F));
      pending_requests.push_back(make_req(ACT_CREATE, 0, 0, 16'd1, 0, 0, 1439, 0, 7'h00));
      pending_requests.push_back(make_req(ACT_CREATE, 0, 0, 16'd2, 1, 1, 10, 20, 7'h01));
      pending_requests.push_back(make_req(ACT_TICK, 11, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_TICK, 1439, 7, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_TICK, 31, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_TICK, 2047, 7, 16'hFFFF, 1, 3, 2047, 2047, 7'h7F));
      pending_requests.push_back(make_req(ACT_MODIFY, 0, 0, 16'd1, 1, 2, 5, 100, 7'h40));
      pending_requests.push_back(make_req(ACT_MODIFY, 0, 0, 16'h1234, 1, 2, 5, 100, 7'h40));
      pending_requests.push_back(make_req(ACT_DELETE, 0, 0, 16'hFFFF, 0, 3, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_DELETE, 0, 0, 16'd0, 0, 1, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_MODIFY, 0, 0, 16'd0, 1, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_DELETE, 0, 0, 16'h7777, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_MAN_ON, 0, 0, 0, 0, 2, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_MAN_ON, 0, 0, 0, 0, 1, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_TICK, 50, 6, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_MAN_OFF, 0, 0, 0, 0, 3, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_MAN_OFF, 0, 0, 0, 0, 2, 0, 0, 0));
      pending_requests.push_back(make_req(3'd6, 2047, 7, 16'hFFFF, 1, 3, 2047, 2047, 7'h7F));
      pending_requests.push_back(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      created_keys = '{16'hFFFF, 16'd1, 16'd2};
      wait_idle();

      // small limits so warnings and forced stops show up; long receiver hold-off
      write_reg(CSR_WARN, 16'd2);
      write_reg(CSR_LIMIT, 16'd4);
      random_phase(90);
      @(posedge clock);
      hold_left <= 600;
      wait_idle();

      // zero limits, with a stretch of no idling
      write_reg(CSR_WARN, 16'd0);
      write_reg(CSR_LIMIT, 16'd0);
      calm = 1'b1;
      random_phase(80);
      wait_idle();
      calm = 1'b0;

      // top limits
      write_reg(CSR_WARN, 16'hFFFF);
      write_reg(CSR_LIMIT, 16'hFFFF);
      random_phase(80);
      wait_idle();

      // warning past the limit, then random small limits
      write_reg(CSR_WARN, 16'd5);
      write_reg(CSR_LIMIT, 16'd3);
      random_phase(50);
      wait_idle();
      write_reg(CSR_WARN, 16'($urandom_range(6)));
      write_reg(CSR_LIMIT, 16'($urandom_range(10)));
      random_phase(50);
      wait_idle();
      repeat (100) @(posedge clock);

      if (errors == 0 && expected_events.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
